// ===== hw/rtl/hcb_pkg.sv =====
// Shared types, constants and codes for the Huffman code builder.
package hcb_pkg;

    localparam int MAX_SYMBOLS_DEF = 64;
    localparam int SYM_W           = 8;
    localparam int FREQ_W          = 24;
    localparam int WEIGHT_W        = 30;
    localparam int LEN_W           = 6;
    localparam int CODE_W          = 63;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT, ST_HFY_NEXT, ST_SD_LDN, ST_SD_LDW, ST_SD_L, ST_SD_LN,
        ST_SD_LW, ST_SD_RN, ST_SD_RW, ST_SD_CHK, ST_SD_SW, ST_MRG_CHK, ST_POP2,
        ST_POP_TOP, ST_POP_LAST, ST_SUM_A, ST_SUM_B, ST_SUM_W, ST_PSH_CHK,
        ST_PSH_PN, ST_PSH_PW, ST_PSH_PUT, ST_ROOT, ST_WK_POP, ST_WK_NODE,
        ST_WK_PUSHR, ST_WK_PUSHL, ST_WK_EMIT, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        CMD_LOAD, CMD_INIT, CMD_HFY_NEXT, CMD_SD_LDN, CMD_SD_LDW, CMD_SD_L,
        CMD_SD_CHILD, CMD_SD_LW, CMD_SD_RW, CMD_SD_CHK, CMD_SD_SW, CMD_RD_TOP,
        CMD_POP_TOP, CMD_POP_LAST, CMD_SUM_A, CMD_SUM_B, CMD_SUM_W, CMD_PSH_CHK,
        CMD_PSH_PN, CMD_PSH_PW, CMD_PSH_PUT, CMD_ROOT, CMD_WK_POP, CMD_WK_NODE,
        CMD_WK_PUSHR, CMD_WK_PUSHL, CMD_WK_EMIT, CMD_DONE
    } t_cmd;

    typedef enum logic [1:0] {
        RET_HFY, RET_POPA, RET_POPB
    } t_ret;

    typedef struct packed {
        logic last_acc;
        logic init_done;
        logic k_zero;
        logic l_in;
        logic r_in;
        logic best_is_i;
        logic size_gt1;
        logic i_zero;
        logic push_lt;
        logic sp_zero;
        logic is_leaf;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/huffman_code_builder.sv =====
// Top level of the Huffman code builder: sequencer plus datapath.
//
//  channel | direction | handshake               | payload
//  in      | to block  | i_in_valid / o_in_stall | i_symbol, i_frequency, i_last_symbol
//  out     | from block| o_out_valid / i_out_stall | o_out_symbol, o_code_length,
//          |           |                         | o_codeword, o_too_many, o_last_code
//
// Loading takes symbol transactions while idle. The transaction flagged last starts a
// build: the heap is filled, then heapified by sifts; each merge pops two nodes, each
// pop sifting down, and pushes their sum node, which rises to its place; then the
// tree is walked, with a code emitted per leaf. All of it runs through memories with
// registered reads.
// Synchronous active-low reset clears the sequencer, counts and output valid; no sweep.
// o_in_stall is high for the whole build; a stalled output holds the walk.
module huffman_code_builder #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [hcb_pkg::SYM_W-1:0]   i_symbol,
    input  logic [hcb_pkg::FREQ_W-1:0]  i_frequency,
    input  logic                        i_last_symbol,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [hcb_pkg::SYM_W-1:0]   o_out_symbol,
    output logic [hcb_pkg::LEN_W-1:0]   o_code_length,
    output logic [hcb_pkg::CODE_W-1:0]  o_codeword,
    output logic                        o_too_many,
    output logic                        o_last_code
);

    hcb_pkg::t_cmd       w_cmd;
    hcb_pkg::t_dp_status w_status;

    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    hcb_datapath #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_in_valid    (i_in_valid),
        .i_symbol      (i_symbol),
        .i_frequency   (i_frequency),
        .i_last_symbol (i_last_symbol),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_symbol  (o_out_symbol),
        .o_code_length (o_code_length),
        .o_codeword    (o_codeword),
        .o_too_many    (o_too_many),
        .o_last_code   (o_last_code)
    );

endmodule

// ===== hw/rtl/hcb_ctrl.sv =====
// Sequencer for loading, heap build, merging and tree walk.
module hcb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hcb_pkg::t_dp_status i_status,
    output hcb_pkg::t_cmd       o_cmd,
    output logic                o_in_stall
);

    hcb_pkg::t_state r_state, n_state;
    hcb_pkg::t_ret   r_ret, n_ret;
    hcb_pkg::t_state w_sd_ret;

    always_comb begin
        unique case (r_ret)
            hcb_pkg::RET_HFY:  w_sd_ret = hcb_pkg::ST_HFY_NEXT;
            hcb_pkg::RET_POPA: w_sd_ret = hcb_pkg::ST_POP2;
            default:           w_sd_ret = hcb_pkg::ST_SUM_A;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state)
            hcb_pkg::ST_IDLE:     if (i_status.last_acc) n_state = hcb_pkg::ST_INIT;
            hcb_pkg::ST_INIT:     if (i_status.init_done) n_state = hcb_pkg::ST_HFY_NEXT;
            hcb_pkg::ST_HFY_NEXT: begin
                n_ret = hcb_pkg::RET_HFY;
                n_state = i_status.k_zero ? hcb_pkg::ST_MRG_CHK : hcb_pkg::ST_SD_LDN;
            end
            hcb_pkg::ST_SD_LDN:   n_state = hcb_pkg::ST_SD_LDW;
            hcb_pkg::ST_SD_LDW:   n_state = hcb_pkg::ST_SD_L;
            hcb_pkg::ST_SD_L:     n_state = i_status.l_in ? hcb_pkg::ST_SD_LN : w_sd_ret;
            hcb_pkg::ST_SD_LN:    n_state = hcb_pkg::ST_SD_LW;
            hcb_pkg::ST_SD_LW:    n_state = i_status.r_in ? hcb_pkg::ST_SD_RN : hcb_pkg::ST_SD_CHK;
            hcb_pkg::ST_SD_RN:    n_state = hcb_pkg::ST_SD_RW;
            hcb_pkg::ST_SD_RW:    n_state = hcb_pkg::ST_SD_CHK;
            hcb_pkg::ST_SD_CHK:   n_state = i_status.best_is_i ? w_sd_ret : hcb_pkg::ST_SD_SW;
            hcb_pkg::ST_SD_SW:    n_state = hcb_pkg::ST_SD_L;
            hcb_pkg::ST_MRG_CHK: begin
                n_ret = hcb_pkg::RET_POPA;
                n_state = i_status.size_gt1 ? hcb_pkg::ST_POP_TOP : hcb_pkg::ST_ROOT;
            end
            hcb_pkg::ST_POP2: begin
                n_ret = hcb_pkg::RET_POPB;
                n_state = hcb_pkg::ST_POP_TOP;
            end
            hcb_pkg::ST_POP_TOP:  n_state = hcb_pkg::ST_POP_LAST;
            hcb_pkg::ST_POP_LAST: n_state = hcb_pkg::ST_SD_LDW;
            hcb_pkg::ST_SUM_A:    n_state = hcb_pkg::ST_SUM_B;
            hcb_pkg::ST_SUM_B:    n_state = hcb_pkg::ST_SUM_W;
            hcb_pkg::ST_SUM_W:    n_state = hcb_pkg::ST_PSH_CHK;
            hcb_pkg::ST_PSH_CHK:  n_state = i_status.i_zero ? hcb_pkg::ST_PSH_PUT : hcb_pkg::ST_PSH_PN;
            hcb_pkg::ST_PSH_PN:   n_state = hcb_pkg::ST_PSH_PW;
            hcb_pkg::ST_PSH_PW:   n_state = i_status.push_lt ? hcb_pkg::ST_PSH_CHK : hcb_pkg::ST_PSH_PUT;
            hcb_pkg::ST_PSH_PUT:  n_state = hcb_pkg::ST_MRG_CHK;
            hcb_pkg::ST_ROOT:     n_state = hcb_pkg::ST_WK_POP;
            hcb_pkg::ST_WK_POP:   n_state = i_status.sp_zero ? hcb_pkg::ST_DONE : hcb_pkg::ST_WK_NODE;
            hcb_pkg::ST_WK_NODE:  n_state = i_status.is_leaf ? hcb_pkg::ST_WK_EMIT : hcb_pkg::ST_WK_PUSHR;
            hcb_pkg::ST_WK_PUSHR: n_state = hcb_pkg::ST_WK_PUSHL;
            hcb_pkg::ST_WK_PUSHL: n_state = hcb_pkg::ST_WK_POP;
            hcb_pkg::ST_WK_EMIT:  if (i_status.out_free) n_state = hcb_pkg::ST_WK_POP;
            hcb_pkg::ST_DONE:     n_state = hcb_pkg::ST_IDLE;
            default:              n_state = hcb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != hcb_pkg::ST_IDLE);
        unique case (r_state)
            hcb_pkg::ST_IDLE:     o_cmd = hcb_pkg::CMD_LOAD;
            hcb_pkg::ST_INIT:     o_cmd = hcb_pkg::CMD_INIT;
            hcb_pkg::ST_HFY_NEXT: o_cmd = hcb_pkg::CMD_HFY_NEXT;
            hcb_pkg::ST_SD_LDN:   o_cmd = hcb_pkg::CMD_SD_LDN;
            hcb_pkg::ST_SD_LDW:   o_cmd = hcb_pkg::CMD_SD_LDW;
            hcb_pkg::ST_SD_L:     o_cmd = hcb_pkg::CMD_SD_L;
            hcb_pkg::ST_SD_LN:    o_cmd = hcb_pkg::CMD_SD_CHILD;
            hcb_pkg::ST_SD_LW:    o_cmd = hcb_pkg::CMD_SD_LW;
            hcb_pkg::ST_SD_RN:    o_cmd = hcb_pkg::CMD_SD_CHILD;
            hcb_pkg::ST_SD_RW:    o_cmd = hcb_pkg::CMD_SD_RW;
            hcb_pkg::ST_SD_CHK:   o_cmd = hcb_pkg::CMD_SD_CHK;
            hcb_pkg::ST_SD_SW:    o_cmd = hcb_pkg::CMD_SD_SW;
            hcb_pkg::ST_MRG_CHK:  o_cmd = hcb_pkg::CMD_RD_TOP;
            hcb_pkg::ST_POP2:     o_cmd = hcb_pkg::CMD_RD_TOP;
            hcb_pkg::ST_POP_TOP:  o_cmd = hcb_pkg::CMD_POP_TOP;
            hcb_pkg::ST_POP_LAST: o_cmd = hcb_pkg::CMD_POP_LAST;
            hcb_pkg::ST_SUM_A:    o_cmd = hcb_pkg::CMD_SUM_A;
            hcb_pkg::ST_SUM_B:    o_cmd = hcb_pkg::CMD_SUM_B;
            hcb_pkg::ST_SUM_W:    o_cmd = hcb_pkg::CMD_SUM_W;
            hcb_pkg::ST_PSH_CHK:  o_cmd = hcb_pkg::CMD_PSH_CHK;
            hcb_pkg::ST_PSH_PN:   o_cmd = hcb_pkg::CMD_PSH_PN;
            hcb_pkg::ST_PSH_PW:   o_cmd = hcb_pkg::CMD_PSH_PW;
            hcb_pkg::ST_PSH_PUT:  o_cmd = hcb_pkg::CMD_PSH_PUT;
            hcb_pkg::ST_ROOT:     o_cmd = hcb_pkg::CMD_ROOT;
            hcb_pkg::ST_WK_POP:   o_cmd = hcb_pkg::CMD_WK_POP;
            hcb_pkg::ST_WK_NODE:  o_cmd = hcb_pkg::CMD_WK_NODE;
            hcb_pkg::ST_WK_PUSHR: o_cmd = hcb_pkg::CMD_WK_PUSHR;
            hcb_pkg::ST_WK_PUSHL: o_cmd = hcb_pkg::CMD_WK_PUSHL;
            hcb_pkg::ST_WK_EMIT:  o_cmd = hcb_pkg::CMD_WK_EMIT;
            hcb_pkg::ST_DONE:     o_cmd = hcb_pkg::CMD_DONE;
            default:              o_cmd = hcb_pkg::CMD_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcb_pkg::ST_IDLE;
            r_ret   <= hcb_pkg::RET_HFY;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hcb_pkg::ST_DONE) |=> (r_state == hcb_pkg::ST_IDLE))
        else $error("build did not return to idle");
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.last_acc |-> (r_state == hcb_pkg::ST_IDLE))
        else $error("symbol taken outside idle");
    a_emit_after_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == hcb_pkg::ST_WK_EMIT) |-> $past(r_state == hcb_pkg::ST_WK_NODE))
        else $error("emit entered without a leaf");

endmodule

// ===== hw/rtl/hcb_datapath.sv =====
// Node store, heap, walk stack and output register of the code builder.
module hcb_datapath #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hcb_pkg::t_cmd               i_cmd,
    output hcb_pkg::t_dp_status         o_status,
    input  logic                        i_in_valid,
    input  logic [hcb_pkg::SYM_W-1:0]   i_symbol,
    input  logic [hcb_pkg::FREQ_W-1:0]  i_frequency,
    input  logic                        i_last_symbol,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [hcb_pkg::SYM_W-1:0]   o_out_symbol,
    output logic [hcb_pkg::LEN_W-1:0]   o_code_length,
    output logic [hcb_pkg::CODE_W-1:0]  o_codeword,
    output logic                        o_too_many,
    output logic                        o_last_code
);

    localparam int IW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CW    = IW + 1;
    localparam int NN    = 2 * MAX_SYMBOLS - 1;
    localparam int NW    = CW;
    localparam int WW    = hcb_pkg::WEIGHT_W;
    localparam int LW    = hcb_pkg::LEN_W;
    localparam int KW    = hcb_pkg::CODE_W;
    localparam int STK_W = NW + LW + KW;

    logic [hcb_pkg::SYM_W-1:0] m_leaf  [MAX_SYMBOLS];
    logic [WW-1:0]             m_wt    [NN];
    logic [NW-1:0]             m_left  [NN];
    logic [NW-1:0]             m_right [NN];
    logic [NW-1:0]             m_heap  [MAX_SYMBOLS];
    logic [STK_W-1:0]          m_stk   [MAX_SYMBOLS];

    logic [hcb_pkg::SYM_W-1:0] rd_leaf;
    logic [WW-1:0]             rd_wt;
    logic [NW-1:0]             rd_left, rd_right, rd_heap;
    logic [STK_W-1:0]          rd_stk;

    logic [CW-1:0] r_cnt, r_k, r_size, r_sp;
    logic          r_ovf;
    logic [IW-1:0] r_i, r_best;
    logic [WW-1:0] r_best_w, r_cur_w, r_sum;
    logic [NW-1:0] r_best_node, r_cur_node, r_child, r_first, r_second, r_next, r_lchild;
    logic [STK_W-1:0] r_wk;

    logic [IW-1:0] ra_leaf, ra_heap, ra_stk, wa_heap, wa_stk;
    logic [NW-1:0] ra_wt, ra_lr, wa_wt;
    logic [WW-1:0] wd_wt;
    logic [NW-1:0] wd_heap;
    logic [STK_W-1:0] wd_stk;
    logic          we_leaf, we_wt, we_lr, we_heap, we_stk;

    logic          w_acc, w_full;
    logic [CW:0]   w_l, w_r;
    logic [CW-1:0] w_k_m1, w_sp_m1;
    logic [IW-1:0] w_p;
    logic [WW-1:0] w_sum;
    logic [NW-1:0] w_stk_node, w_wk_node;
    logic [LW-1:0] w_wk_len;
    logic [KW-1:0] w_wk_code;

    function automatic logic [IW-1:0] w_size_m1_idx(input logic [CW-1:0] size);
        logic [CW-1:0] v;
        v = size - 1'b1;
        return v[IW-1:0];
    endfunction

    assign w_acc      = (i_cmd == hcb_pkg::CMD_LOAD) && i_in_valid;
    assign w_full     = (r_cnt == CW'(MAX_SYMBOLS));
    assign w_l        = {1'b0, r_i, 1'b1};
    assign w_r        = w_l + 1'b1;
    assign w_k_m1     = r_k - 1'b1;
    assign w_sp_m1    = r_sp - 1'b1;
    assign w_p        = IW'((r_i - 1'b1) >> 1);
    assign w_sum      = r_sum + rd_wt;
    assign w_stk_node = rd_stk[STK_W-1 -: NW];
    assign w_wk_node  = r_wk[STK_W-1 -: NW];
    assign w_wk_len   = r_wk[KW +: LW];
    assign w_wk_code  = r_wk[KW-1:0];

    always_comb begin
        o_status.last_acc  = w_acc && i_last_symbol;
        o_status.init_done = (r_k == r_cnt - 1'b1);
        o_status.k_zero    = (r_k == '0);
        o_status.l_in      = (w_l < {1'b0, r_size});
        o_status.r_in      = (w_r < {1'b0, r_size});
        o_status.best_is_i = (r_best == r_i);
        o_status.size_gt1  = (r_size > CW'(1));
        o_status.i_zero    = (r_i == '0);
        o_status.push_lt   = (r_sum < rd_wt);
        o_status.sp_zero   = (r_sp == '0);
        o_status.is_leaf   = (w_stk_node < r_cnt);
        o_status.out_free  = !o_out_valid || !i_out_stall;
    end

    always_comb begin
        ra_leaf = w_wk_node[IW-1:0];
        ra_heap = '0;
        ra_wt   = rd_heap;
        ra_lr   = w_stk_node;
        ra_stk  = w_sp_m1[IW-1:0];
        we_leaf = 1'b0;
        we_wt   = 1'b0;
        we_lr   = 1'b0;
        we_heap = 1'b0;
        we_stk  = 1'b0;
        wa_wt   = r_next;
        wd_wt   = w_sum;
        wa_heap = r_i;
        wd_heap = r_next;
        wa_stk  = r_sp[IW-1:0];
        wd_stk  = {r_lchild, LW'(w_wk_len + 1'b1), KW'({w_wk_code, 1'b0})};
        unique case (i_cmd)
            hcb_pkg::CMD_LOAD: begin
                we_leaf = w_acc && !w_full;
                we_wt   = w_acc && !w_full;
                wa_wt   = r_cnt;
                wd_wt   = WW'(i_frequency);
            end
            hcb_pkg::CMD_INIT: begin
                we_heap = 1'b1;
                wa_heap = r_k[IW-1:0];
                wd_heap = r_k;
            end
            hcb_pkg::CMD_HFY_NEXT: ra_heap = w_k_m1[IW-1:0];
            hcb_pkg::CMD_SD_L:     ra_heap = w_l[IW-1:0];
            hcb_pkg::CMD_SD_LW:    ra_heap = w_r[IW-1:0];
            hcb_pkg::CMD_SD_CHK: begin
                we_heap = !o_status.best_is_i;
                wd_heap = r_best_node;
            end
            hcb_pkg::CMD_SD_SW: begin
                we_heap = 1'b1;
                wa_heap = r_best;
                wd_heap = r_cur_node;
            end
            hcb_pkg::CMD_POP_TOP:  ra_heap = w_size_m1_idx(r_size);
            hcb_pkg::CMD_POP_LAST: begin
                we_heap = 1'b1;
                wa_heap = '0;
                wd_heap = rd_heap;
            end
            hcb_pkg::CMD_SUM_A: ra_wt = r_first;
            hcb_pkg::CMD_SUM_B: ra_wt = r_second;
            hcb_pkg::CMD_SUM_W: begin
                we_wt = 1'b1;
                we_lr = 1'b1;
            end
            hcb_pkg::CMD_PSH_CHK: ra_heap = w_p;
            hcb_pkg::CMD_PSH_PW: begin
                we_heap = o_status.push_lt;
                wd_heap = r_child;
            end
            hcb_pkg::CMD_PSH_PUT: we_heap = 1'b1;
            hcb_pkg::CMD_ROOT: begin
                we_stk = 1'b1;
                wa_stk = '0;
                wd_stk = {rd_heap, {LW{1'b0}}, {KW{1'b0}}};
            end
            hcb_pkg::CMD_WK_NODE: ra_leaf = w_stk_node[IW-1:0];
            hcb_pkg::CMD_WK_PUSHR: begin
                we_stk = 1'b1;
                wd_stk = {rd_right, LW'(w_wk_len + 1'b1), KW'({w_wk_code, 1'b1})};
            end
            hcb_pkg::CMD_WK_PUSHL: we_stk = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_leaf) m_leaf[r_cnt[IW-1:0]] <= i_symbol;
        rd_leaf <= m_leaf[ra_leaf];
    end

    always_ff @(posedge i_clk) begin
        if (we_wt) m_wt[wa_wt] <= wd_wt;
        rd_wt <= m_wt[ra_wt];
    end

    always_ff @(posedge i_clk) begin
        if (we_lr) begin
            m_left[r_next]  <= r_first;
            m_right[r_next] <= r_second;
        end
        rd_left  <= m_left[ra_lr];
        rd_right <= m_right[ra_lr];
    end

    always_ff @(posedge i_clk) begin
        if (we_heap) m_heap[wa_heap] <= wd_heap;
        rd_heap <= m_heap[ra_heap];
    end

    always_ff @(posedge i_clk) begin
        if (we_stk) m_stk[wa_stk] <= wd_stk;
        rd_stk <= m_stk[ra_stk];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_size      <= '0;
            r_sp        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && (i_cmd != hcb_pkg::CMD_WK_EMIT))
                o_out_valid <= 1'b0;
            unique case (i_cmd)
                hcb_pkg::CMD_LOAD: begin
                    if (w_acc) begin
                        if (w_full) r_ovf <= 1'b1;
                        else r_cnt <= r_cnt + 1'b1;
                    end
                    r_k <= '0;
                end
                hcb_pkg::CMD_INIT: begin
                    if (o_status.init_done) begin
                        r_size <= r_cnt;
                        r_k    <= r_cnt >> 1;
                        r_next <= r_cnt;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                hcb_pkg::CMD_HFY_NEXT: begin
                    if (!o_status.k_zero) begin
                        r_k <= w_k_m1;
                        r_i <= w_k_m1[IW-1:0];
                    end
                end
                hcb_pkg::CMD_SD_LDN: r_cur_node <= rd_heap;
                hcb_pkg::CMD_SD_LDW: r_cur_w <= rd_wt;
                hcb_pkg::CMD_SD_L: begin
                    r_best   <= r_i;
                    r_best_w <= r_cur_w;
                end
                hcb_pkg::CMD_SD_CHILD: r_child <= rd_heap;
                hcb_pkg::CMD_SD_LW: begin
                    if (rd_wt < r_best_w) begin
                        r_best      <= w_l[IW-1:0];
                        r_best_w    <= rd_wt;
                        r_best_node <= r_child;
                    end
                end
                hcb_pkg::CMD_SD_RW: begin
                    if (rd_wt < r_best_w) begin
                        r_best      <= w_r[IW-1:0];
                        r_best_w    <= rd_wt;
                        r_best_node <= r_child;
                    end
                end
                hcb_pkg::CMD_SD_SW: r_i <= r_best;
                hcb_pkg::CMD_POP_TOP: begin
                    r_first  <= r_second;
                    r_second <= rd_heap;
                end
                hcb_pkg::CMD_POP_LAST: begin
                    r_cur_node <= rd_heap;
                    r_size     <= r_size - 1'b1;
                    r_i        <= '0;
                end
                hcb_pkg::CMD_SUM_B: r_sum <= rd_wt;
                hcb_pkg::CMD_SUM_W: begin
                    r_sum  <= w_sum;
                    r_i    <= r_size[IW-1:0];
                    r_size <= r_size + 1'b1;
                end
                hcb_pkg::CMD_PSH_PN: r_child <= rd_heap;
                hcb_pkg::CMD_PSH_PW: if (o_status.push_lt) r_i <= w_p;
                hcb_pkg::CMD_PSH_PUT: r_next <= r_next + 1'b1;
                hcb_pkg::CMD_ROOT: r_sp <= CW'(1);
                hcb_pkg::CMD_WK_POP: if (!o_status.sp_zero) r_sp <= w_sp_m1;
                hcb_pkg::CMD_WK_NODE: r_wk <= rd_stk;
                hcb_pkg::CMD_WK_PUSHR: begin
                    r_lchild <= rd_left;
                    r_sp     <= r_sp + 1'b1;
                end
                hcb_pkg::CMD_WK_PUSHL: r_sp <= r_sp + 1'b1;
                hcb_pkg::CMD_WK_EMIT: begin
                    if (o_status.out_free) begin
                        o_out_valid   <= 1'b1;
                        o_out_symbol  <= rd_leaf;
                        o_code_length <= w_wk_len;
                        o_codeword    <= w_wk_code;
                        o_too_many    <= r_ovf;
                        o_last_code   <= (r_sp == '0);
                    end
                end
                hcb_pkg::CMD_DONE: begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_SYMBOLS))
        else $error("symbol count beyond capacity");
    a_size_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd != hcb_pkg::CMD_LOAD && i_cmd != hcb_pkg::CMD_INIT) |-> r_size <= r_cnt)
        else $error("heap larger than symbol set");
    a_sp_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CW'(MAX_SYMBOLS))
        else $error("walk stack overrun");

endmodule
